// ===== rtl/core/ohcs_pkg.sv =====
// Shared types and constants for the overheat cutoff with siren block.
package ohcs_pkg;

    localparam int SAMPLES_PER_AVERAGE = 16;
    localparam int SAMPLE_W = 12;
    localparam int IDX_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam int SUM_W = SAMPLE_W + IDX_W;
    localparam int TICK_W = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_OVERHEAT = 2'd0;
    localparam logic [1:0] REG_RECOVERY = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    localparam logic [SAMPLE_W-1:0] OVERHEAT_RESET = SAMPLE_W'(1750);
    localparam logic [SAMPLE_W-1:0] RECOVERY_RESET = SAMPLE_W'(1800);
    localparam logic [TICK_W-1:0] INTERVAL_RESET = TICK_W'(200);

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] trip_level;
        logic [SAMPLE_W-1:0] clear_level;
        logic [TICK_W-1:0] flash_period;
    } cfg_t;

    typedef struct packed {
        logic alarm_flag;
        logic red_phase;
        logic [TICK_W-1:0] siren_ticks;
        logic [SUM_W-1:0] sample_sum;
        logic [IDX_W-1:0] sample_index;
        logic [SAMPLE_W-1:0] last_average;
    } state_t;

    typedef struct packed {
        logic load_on;
        logic red_led;
        logic blue_led;
        logic alarm_active;
        logic [SAMPLE_W-1:0] average;
        logic average_done;
    } result_t;

endpackage

// ===== rtl/core/overheat_cutoff_with_siren_top.sv =====
// Top level: overheat cutoff with hysteresis and alternating LED siren.
// Pipeline: input register, then result register, which offers the result.
// Throughput: one transaction per cycle unless m_axis_tready is low; set by the
//   input register feeding the combinational update into the result register.
// Reset (rst_n low, async): normal mode, red phase set, counters and average
//   cleared, thresholds 1750/1800 and siren interval 200; pipeline empty.
module overheat_cutoff_with_siren_top
(
    input  logic clk,
    input  logic rst_n,

    // Configuration write port
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,

    // Input stream
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample, zero padded
    input  logic s_axis_tuser,          // [0] kind: 0 tick, 1 ADC sample

    // Result stream
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] average, zero padded
    output logic [4:0] m_axis_tuser     // load_on, red_led, blue_led,
                                        // alarm_active, average_done
);

    ohcs_pkg::cfg_t cfg_reg;
    ohcs_pkg::state_t state_reg;
    ohcs_pkg::state_t state_next;
    ohcs_pkg::result_t res_next;
    ohcs_pkg::result_t res_reg;

    logic in_valid_reg;
    logic in_kind_reg;
    logic [ohcs_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic out_valid_reg;
    logic advance;

    // The held input moves into the result register whenever that register
    // is empty or being drained; the input register refills in the same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trip_level <= ohcs_pkg::OVERHEAT_RESET;
            cfg_reg.clear_level <= ohcs_pkg::RECOVERY_RESET;
            cfg_reg.flash_period <= ohcs_pkg::INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ohcs_pkg::REG_OVERHEAT:
                    cfg_reg.trip_level <= cfg_data[ohcs_pkg::SAMPLE_W-1:0];
                ohcs_pkg::REG_RECOVERY:
                    cfg_reg.clear_level <= cfg_data[ohcs_pkg::SAMPLE_W-1:0];
                ohcs_pkg::REG_INTERVAL:
                    cfg_reg.flash_period <= cfg_data[ohcs_pkg::TICK_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Input register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_sample_reg <= s_axis_tdata[ohcs_pkg::SAMPLE_W-1:0];
        end
    end

    ohcs_step u_step
    (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .kind   (in_kind_reg),
        .sample (in_sample_reg),
        .nxt    (state_next),
        .res    (res_next)
    );

    // Block state commits only when its transaction lands in the result reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.alarm_flag <= 1'b0;
            state_reg.red_phase <= 1'b1;
            state_reg.siren_ticks <= '0;
            state_reg.sample_sum <= '0;
            state_reg.sample_index <= '0;
            state_reg.last_average <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {{(16 - ohcs_pkg::SAMPLE_W){1'b0}}, res_reg.average};
    assign m_axis_tuser = {res_reg.average_done, res_reg.alarm_active,
                           res_reg.blue_led, res_reg.red_led, res_reg.load_on};

endmodule

// ===== rtl/core/ohcs_step.sv =====
// Next-state and result logic for one tick or sample transaction.
module ohcs_step
(
    input  ohcs_pkg::cfg_t cfg,
    input  ohcs_pkg::state_t cur,
    input  logic kind,
    input  logic [ohcs_pkg::SAMPLE_W-1:0] sample,
    output ohcs_pkg::state_t nxt,
    output ohcs_pkg::result_t res
);

    logic [ohcs_pkg::SUM_W-1:0] sum_inc;
    logic [ohcs_pkg::SUM_W-1:0] avg_wide;
    logic [ohcs_pkg::SAMPLE_W-1:0] avg;
    logic group_end;
    logic [ohcs_pkg::TICK_W:0] ticks_inc;
    logic done;

    assign sum_inc = cur.sample_sum + ohcs_pkg::SUM_W'(sample);
    assign avg_wide = sum_inc / ohcs_pkg::SUM_W'(ohcs_pkg::SAMPLES_PER_AVERAGE);
    assign avg = avg_wide[ohcs_pkg::SAMPLE_W-1:0];
    assign group_end =
        (cur.sample_index == ohcs_pkg::IDX_W'(ohcs_pkg::SAMPLES_PER_AVERAGE - 1));
    assign ticks_inc = {1'b0, cur.siren_ticks} + (ohcs_pkg::TICK_W + 1)'(1);

    always_comb
    begin
        nxt = cur;
        done = 1'b0;
        if (kind == ohcs_pkg::KIND_SAMPLE)
        begin
            if (group_end)
            begin
                done = 1'b1;
                nxt.last_average = avg;
                nxt.sample_sum = '0;
                nxt.sample_index = '0;
                if (!cur.alarm_flag && (avg <= cfg.trip_level))
                begin
                    nxt.alarm_flag = 1'b1;
                    nxt.red_phase = 1'b1;
                    nxt.siren_ticks = '0;
                end
                // hysteresis exit, may fire on the same average as entry
                if (nxt.alarm_flag && (avg >= cfg.clear_level))
                begin
                    nxt.alarm_flag = 1'b0;
                end
            end
            else
            begin
                nxt.sample_sum = sum_inc;
                nxt.sample_index = cur.sample_index + ohcs_pkg::IDX_W'(1);
            end
        end
        else if (cur.alarm_flag)
        begin
            if (ticks_inc >= {1'b0, cfg.flash_period})
            begin
                nxt.siren_ticks = '0;
                nxt.red_phase = !cur.red_phase;
            end
            else
            begin
                nxt.siren_ticks = ticks_inc[ohcs_pkg::TICK_W-1:0];
            end
        end
    end

    always_comb
    begin
        res.load_on = !nxt.alarm_flag;
        res.red_led = nxt.alarm_flag && nxt.red_phase;
        res.blue_led = nxt.alarm_flag && !nxt.red_phase;
        res.alarm_active = nxt.alarm_flag;
        res.average = nxt.last_average;
        res.average_done = done;
    end

endmodule
